// ===== sv/rlm_pkg.sv =====
// ---------------------------------------------------------------------------
// rlm_pkg
// Shared types and constants of the rms level meter with history.
// ---------------------------------------------------------------------------
package rlm_pkg;

  // input opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // result kinds
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_RAW_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN   = 3'd5;
  localparam int CFG_DATA_W = 16;
  localparam int HLEN_REG_W = 10;

  // reset values
  localparam logic [15:0] GAIN_RESET       = 16'd4096;
  localparam logic [15:0] FULL_SCALE_RESET = 16'd6554;
  localparam logic [HLEN_REG_W-1:0] HLEN_RESET = 10'd400;

  // Q0.16 weights
  localparam logic [15:0] W_OLD      = 16'd60948;
  localparam logic [15:0] W_NEW      = 16'd4588;
  localparam logic [15:0] W_FILT     = 16'd13107;
  localparam logic [15:0] W_FILT_OLD = 16'd52429;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
    logic               last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] smoothed_level;
    logic [15:0] scaled_level;
    logic [15:0] history_mean;
    logic [15:0] filtered_mean;
  } out_item_t;

endpackage

// ===== sv/rlm_div.sv =====
// ---------------------------------------------------------------------------
// rlm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rlm_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/rlm_sqrt.sv =====
// ---------------------------------------------------------------------------
// rlm_sqrt
// Floor square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module rlm_sqrt #(
  parameter int IN_W = 44
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   radicand,
  output logic              done,
  output logic [15:0]       root_sat
);

  localparam int QW    = IN_W + (IN_W % 2);
  localparam int H     = QW / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [QW-1:0]    x;
  logic [H:0]       rem;
  logic [H-1:0]     root;
  logic [H+2:0]     r2;
  logic [H+2:0]     trial;
  logic             fits;

  assign r2    = {rem, x[QW-1:QW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = r2 >= trial;
  assign root_sat = (root > H'(16'hFFFF)) ? 16'hFFFF : root[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(H);
        x    <= QW'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x    <= {x[QW-3:0], 2'b00};
        rem  <= fits ? (H+1)'(r2 - trial) : r2[H:0];
        root <= {root[H-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/rms_level_meter_with_history.sv =====
// ---------------------------------------------------------------------------
// rms_level_meter_with_history
// Audio rms level meter with exponential smoothing and a level history.
// ---------------------------------------------------------------------------
// one item at a time: an ordinary frame squares and accumulates its samples
// (squares go through a shared 24x16 multiplier); a buffer-end frame adds a
// bit-serial divide, a 2-bit-per-cycle root and up to 7 multiply steps; an
// update tick runs two divides (mapping to full scale, history mean),
// and a muted or full-scale tick skips the first of them. after reset and
// after every history_length write the history store is zeroed one entry per
// cycle, during which no input transaction is taken; config writes are always
// taken. a finished result waits in an output register while the next input
// transaction is accepted.
module rms_level_meter_with_history #(
  parameter int HISTORY_DEPTH     = 512,
  parameter int MAX_BUFFER_FRAMES = 512,
  parameter int SAMPLE_WIDTH      = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rlm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rlm_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // widths
  localparam int SW    = SAMPLE_WIDTH;
  localparam int CNT_W = $clog2(MAX_BUFFER_FRAMES + 1);
  localparam int SUM_W = 2 * SW + CNT_W;
  localparam int E_M   = 34 - 2 * SW;   // mono scale exponent
  localparam int E_S   = E_M - 2;       // stereo scale exponent
  localparam int NSH_M = (E_M > 0) ? E_M : 0;
  localparam int DSH_M = (E_M < 0) ? -E_M : 0;
  localparam int NSH_S = (E_S > 0) ? E_S : 0;
  localparam int DSH_S = (E_S < 0) ? -E_S : 0;
  localparam int NSH   = (NSH_M > NSH_S) ? NSH_M : NSH_S;
  localparam int DSH   = (DSH_M > DSH_S) ? DSH_M : DSH_S;
  localparam int NUM_W = SUM_W + NSH;
  localparam int DEN_W = CNT_W + 1 + DSH;
  localparam int POS_W = $clog2(HISTORY_DEPTH);
  localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W = 16 + LEN_W;
  localparam int DN0   = (NUM_W > 32) ? NUM_W : 32;
  localparam int DN    = (DN0 > TOT_W) ? DN0 : TOT_W;
  localparam int DD0   = (DEN_W > 16) ? DEN_W : 16;
  localparam int DD    = (DD0 > LEN_W) ? DD0 : LEN_W;
  localparam int MA_W  = (SW > 24) ? SW : 24;
  localparam int MB_W  = (SW > 16) ? SW : 16;
  localparam int PW    = MA_W + MB_W;
  localparam int CW    = (LEN_W > rlm_pkg::HLEN_REG_W) ? LEN_W : rlm_pkg::HLEN_REG_W;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_F_SQ1  = 20'h00002,
    S_F_SQ2  = 20'h00004,
    S_F_ACC  = 20'h00008,
    S_B_DIV  = 20'h00010,
    S_B_SQRT = 20'h00020,
    S_B_G1M  = 20'h00040,
    S_B_G1A  = 20'h00080,
    S_B_SM1  = 20'h00100,
    S_B_SM2  = 20'h00200,
    S_B_SM3  = 20'h00400,
    S_B_G2M  = 20'h00800,
    S_B_G2A  = 20'h01000,
    S_T_SC   = 20'h02000,
    S_T_HIST = 20'h04000,
    S_T_MEAN = 20'h08000,
    S_T_F1   = 20'h10000,
    S_T_F2   = 20'h20000,
    S_T_F3   = 20'h40000,
    S_EMIT   = 20'h80000
  } state_t;

  state_t state;

  // configuration
  logic                            stereo_mode;
  logic                            use_raw_level;
  logic                            mute;
  logic [15:0]                     input_gain;
  logic [15:0]                     full_scale_level;
  logic [rlm_pkg::HLEN_REG_W-1:0]  history_length;
  logic                            hist_clear_req;

  // datapath state
  rlm_pkg::in_item_t item;
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  frame_count;
  logic [15:0]       level_register;
  logic [15:0]       lv;
  logic [15:0]       scaled;
  logic [15:0]       mean;
  logic [POS_W-1:0]  history_position;
  logic [TOT_W-1:0]  history_total;
  logic [23:0]       smoothed_mean;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     acc;
  logic              sub_go;
  logic              res_kind;

  // clearing pass
  logic              clr_busy;
  logic [POS_W-1:0]  clr_addr;

  // history memory
  logic [15:0]       hist_mem [HISTORY_DEPTH];
  logic [15:0]       hist_rd;
  logic              hist_we;
  logic [POS_W-1:0]  hist_waddr;
  logic [15:0]       hist_wdata;

  // shared multiplier operands
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;

  // sample magnitudes
  logic [23:0]       sf_ext;
  logic [23:0]       ss_ext;
  logic [SW-1:0]     s1;
  logic [SW-1:0]     s2;
  logic [SW-1:0]     s1_abs;
  logic [SW-1:0]     s2_abs;
  logic              room;

  // effective history length and position
  logic [CW-1:0]     hl_x;
  logic [LEN_W-1:0]  eff_len;
  logic [POS_W-1:0]  pos_eff;
  logic [POS_W:0]    pos_inc;

  // divider and root
  logic              div_start;
  logic [DN-1:0]     div_num;
  logic [DD-1:0]     div_den;
  logic              div_done;
  logic [DN-1:0]     div_quo;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [15:0]       sqrt_root;

  // rounding helpers
  logic [32:0]       g_sum;
  logic [15:0]       g_sat;
  logic [33:0]       s_sum;
  logic [15:0]       s_sat;
  logic [PW:0]       f_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !clr_busy;

  // sign-extend the field, keep SAMPLE_WIDTH bits, take the magnitude
  assign sf_ext = {{8{item.sample_first[15]}}, item.sample_first};
  assign ss_ext = {{8{item.sample_second[15]}}, item.sample_second};
  assign s1     = sf_ext[SW-1:0];
  assign s2     = ss_ext[SW-1:0];
  assign s1_abs = s1[SW-1] ? SW'(-s1) : s1;
  assign s2_abs = s2[SW-1] ? SW'(-s2) : s2;
  assign room   = frame_count < CNT_W'(MAX_BUFFER_FRAMES);

  // zero acts as one, oversize as the full depth
  assign hl_x    = CW'(history_length);
  assign eff_len = (hl_x == '0) ? LEN_W'(1) :
                   (hl_x > CW'(HISTORY_DEPTH)) ? LEN_W'(HISTORY_DEPTH) : LEN_W'(hl_x);
  assign pos_eff = ((POS_W+1)'(history_position) >= (POS_W+1)'(eff_len)) ? '0 :
                   history_position;
  assign pos_inc = (POS_W+1)'(history_position) + 1'b1;

  // gain product rounding, saturated
  assign g_sum = {1'b0, prod[31:0]} + 33'd2048;
  assign g_sat = (|g_sum[32:28]) ? 16'hFFFF : g_sum[27:12];
  // weighted level sum rounding, saturated
  assign s_sum = {2'b00, acc[31:0]} + {2'b00, prod[31:0]} + 34'd32768;
  assign s_sat = (|s_sum[33:32]) ? 16'hFFFF : s_sum[31:16];
  // history mean filter sum
  assign f_sum = {1'b0, acc} + {1'b0, prod} + (PW+1)'(32768);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_F_SQ1: begin
        mul_a = MA_W'(s1_abs);
        mul_b = MB_W'(s1_abs);
      end
      S_F_SQ2: begin
        mul_a = MA_W'(s2_abs);
        mul_b = MB_W'(s2_abs);
      end
      S_B_G1M, S_B_G2M: begin
        mul_a = MA_W'(lv);
        mul_b = MB_W'(input_gain);
      end
      S_B_SM1: begin
        mul_a = MA_W'(level_register);
        mul_b = MB_W'(rlm_pkg::W_OLD);
      end
      S_B_SM2: begin
        mul_a = MA_W'(lv);
        mul_b = MB_W'(rlm_pkg::W_NEW);
      end
      S_T_F1: begin
        mul_a = MA_W'(smoothed_mean);
        mul_b = MB_W'(rlm_pkg::W_FILT_OLD);
      end
      S_T_F2: begin
        mul_a = MA_W'({mean, 8'h00});
        mul_b = MB_W'(rlm_pkg::W_FILT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operand selection
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state)
      S_B_DIV: begin
        if (stereo_mode) begin
          div_num = DN'(NUM_W'(square_sum) << NSH_S);
          div_den = DD'(DEN_W'({frame_count, 1'b0}) << DSH_S);
        end else begin
          div_num = DN'(NUM_W'(square_sum) << NSH_M);
          div_den = DD'(DEN_W'(frame_count) << DSH_M);
        end
      end
      S_T_SC: begin
        div_num = DN'({level_register, 16'h0000});
        div_den = DD'(full_scale_level);
      end
      S_T_MEAN: begin
        div_num = DN'(history_total);
        div_den = DD'(eff_len);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_start = !sub_go && ((state == S_B_DIV) || (state == S_T_MEAN) ||
                     ((state == S_T_SC) && !mute && (level_register < full_scale_level)));
  assign sqrt_start = !sub_go && (state == S_B_SQRT);

  rlm_div #(
    .NUM_W (DN),
    .DEN_W (DD)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rlm_sqrt #(
    .IN_W (DN)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_quo),
    .done     (sqrt_done),
    .root_sat (sqrt_root)
  );

  // history memory write port: clearing pass or history update
  assign hist_we    = clr_busy || (state == S_T_HIST);
  assign hist_waddr = clr_busy ? clr_addr : history_position;
  assign hist_wdata = clr_busy ? 16'h0000 : scaled;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd <= hist_mem[pos_eff];
  end

  // configuration register writes
  assign hist_clear_req = cfg_valid && cfg_ready && (cfg_index == rlm_pkg::REG_HISTORY_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode      <= 1'b0;
      use_raw_level    <= 1'b0;
      mute             <= 1'b0;
      input_gain       <= rlm_pkg::GAIN_RESET;
      full_scale_level <= rlm_pkg::FULL_SCALE_RESET;
      history_length   <= rlm_pkg::HLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rlm_pkg::REG_STEREO_MODE:   stereo_mode      <= cfg_data[0];
        rlm_pkg::REG_USE_RAW_LEVEL: use_raw_level    <= cfg_data[0];
        rlm_pkg::REG_MUTE:          mute             <= cfg_data[0];
        rlm_pkg::REG_INPUT_GAIN:    input_gain       <= cfg_data;
        rlm_pkg::REG_FULL_SCALE:    full_scale_level <= cfg_data;
        rlm_pkg::REG_HISTORY_LEN:   history_length   <= cfg_data[rlm_pkg::HLEN_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a * mul_b);
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      square_sum       <= '0;
      frame_count      <= '0;
      level_register   <= '0;
      history_position <= '0;
      history_total    <= '0;
      smoothed_mean    <= '0;
      sub_go           <= 1'b0;
      out_valid        <= 1'b0;
      clr_busy         <= 1'b1;
      clr_addr         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // clearing pass, restarted by any history_length write
      if (hist_clear_req) begin
        clr_busy         <= 1'b1;
        clr_addr         <= '0;
        history_position <= '0;
        history_total    <= '0;
        smoothed_mean    <= '0;
      end else if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == POS_W'(HISTORY_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item  <= in_data;
            state <= (in_data.opcode == rlm_pkg::OP_TICK) ? S_T_SC : S_F_SQ1;
          end
        end

        // frame: accumulate squares
        S_F_SQ1: state <= S_F_SQ2;
        S_F_SQ2: begin
          if (room) begin
            square_sum <= square_sum + SUM_W'(prod);
          end
          state <= S_F_ACC;
        end
        S_F_ACC: begin
          if (room) begin
            if (stereo_mode) begin
              square_sum <= square_sum + SUM_W'(prod);
            end
            frame_count <= frame_count + 1'b1;
          end
          state <= item.last_of_buffer ? S_B_DIV : S_IDLE;
        end

        // buffer end: mean square, root, smoothing (skipped for a raw mono level), gain
        S_B_DIV: begin
          sub_go <= 1'b1;
          if (div_done) begin
            sub_go      <= 1'b0;
            square_sum  <= '0;
            frame_count <= '0;
            state       <= S_B_SQRT;
          end
        end
        S_B_SQRT: begin
          sub_go <= 1'b1;
          if (sqrt_done) begin
            sub_go <= 1'b0;
            lv     <= sqrt_root;
            if (stereo_mode) begin
              state <= S_B_G1M;
            end else if (use_raw_level) begin
              state <= S_B_G2M;
            end else begin
              state <= S_B_SM1;
            end
          end
        end
        S_B_G1M: state <= S_B_G1A;
        S_B_G1A: begin
          lv    <= g_sat;
          state <= S_B_SM1;
        end
        S_B_SM1: state <= S_B_SM2;
        S_B_SM2: begin
          acc   <= prod;
          state <= S_B_SM3;
        end
        S_B_SM3: begin
          lv    <= s_sat;
          state <= S_B_G2M;
        end
        S_B_G2M: state <= S_B_G2A;
        S_B_G2A: begin
          level_register <= g_sat;
          res_kind       <= rlm_pkg::KIND_LEVEL;
          state          <= S_EMIT;
        end

        // update tick: map, history, mean, filter
        S_T_SC: begin
          history_position <= pos_eff;
          if (mute) begin
            scaled <= 16'h0000;
            state  <= S_T_HIST;
          end else if (level_register >= full_scale_level) begin
            scaled <= 16'hFFFF;
            state  <= S_T_HIST;
          end else begin
            sub_go <= 1'b1;
            if (div_done) begin
              sub_go <= 1'b0;
              scaled <= div_quo[15:0];
              state  <= S_T_HIST;
            end
          end
        end
        S_T_HIST: begin
          history_total    <= history_total - TOT_W'(hist_rd) + TOT_W'(scaled);
          history_position <= (pos_inc >= (POS_W+1)'(eff_len)) ? '0 : pos_inc[POS_W-1:0];
          state            <= S_T_MEAN;
        end
        S_T_MEAN: begin
          sub_go <= 1'b1;
          if (div_done) begin
            sub_go <= 1'b0;
            mean   <= div_quo[15:0];
            state  <= S_T_F1;
          end
        end
        S_T_F1: state <= S_T_F2;
        S_T_F2: begin
          acc   <= prod;
          state <= S_T_F3;
        end
        S_T_F3: begin
          smoothed_mean <= f_sum[39:16];
          res_kind      <= rlm_pkg::KIND_TICK;
          state         <= S_EMIT;
        end

        // hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.result_kind    <= res_kind;
            out_data.smoothed_level <= level_register;
            if (res_kind == rlm_pkg::KIND_TICK) begin
              out_data.scaled_level  <= scaled;
              out_data.history_mean  <= mean;
              out_data.filtered_mean <= smoothed_mean[23:8];
            end else begin
              out_data.scaled_level  <= 16'h0000;
              out_data.history_mean  <= 16'h0000;
              out_data.filtered_mean <= 16'h0000;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rlm_checker.sv =====
// ---------------------------------------------------------------------------
// rlm_checker
// Port-level checks on the rms level meter with history.
// ---------------------------------------------------------------------------
module rlm_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input rlm_pkg::out_item_t out_data
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // buffer-end reports carry only the level
  a_level_zeros: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == rlm_pkg::KIND_LEVEL) |->
      (out_data.scaled_level == 16'h0000) && (out_data.history_mean == 16'h0000) &&
      (out_data.filtered_mean == 16'h0000))
    else $error("buffer-end report with tick fields set");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind rms_level_meter_with_history rlm_checker u_rlm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
